>>> rtl/cbm_pkg.sv
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

    // interrupt fires on a tick that finds the counter at or past this many cycles
    localparam int IRQ_LIMIT = 4096;
    // the counter can overshoot the limit by at most one tick's elapsed_cycles value
    localparam int CNT_W = $clog2(IRQ_LIMIT + 256);

    // command codes carried in tuser
    localparam logic [1:0] CMD_WRITE      = 2'd0;
    localparam logic [1:0] CMD_TICK       = 2'd1;
    localparam logic [1:0] CMD_SOFT_RESET = 2'd2;

    // 8K address ranges, upper three address bits
    localparam logic [2:0] RANGE_8000 = 3'b100;
    localparam logic [2:0] RANGE_A000 = 3'b101;
    localparam logic [2:0] RANGE_C000 = 3'b110;
    localparam logic [2:0] RANGE_E000 = 3'b111;

    // fixed banks
    localparam logic [4:0] BANK_FIXED_6000 = 5'd6;
    localparam logic [4:0] BANK_FIXED_8000 = 5'd4;
    localparam logic [4:0] BANK_FIXED_A000 = 5'd5;
    localparam logic [4:0] BANK_FIXED_E000 = 5'd7;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic [7:0]  elapsed_cycles;
    } cbm_item_t;

    typedef struct packed {
        logic [2:0]       inner_bank;
        logic [7:0]       outer_select;
        logic [CNT_W-1:0] cycle_count;
        logic             count_enabled;
        logic             irq_pending;
    } cbm_state_t;

    typedef struct packed {
        logic [4:0] bank_6000;
        logic [4:0] bank_8000;
        logic [4:0] bank_a000;
        logic [4:0] bank_c000;
        logic [4:0] bank_e000;
        logic [6:0] chr_bank;
        logic       mirror_horizontal;
        logic       irq_line;
    } cbm_result_t;

endpackage

>>> rtl/cbm_state.sv
// mapper register file and interrupt counter update
module cbm_state
    import cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       fire,
    input  cbm_item_t  item,
    output cbm_state_t state_cur,
    output cbm_state_t state_next
);

    cbm_state_t state_reg;
    logic       variant_reg;

    // next state for the item being retired
    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            unique case (item.command)
                CMD_WRITE:
                begin
                    unique case (item.bus_address[15:13])
                        RANGE_8000:
                        begin
                            state_next.count_enabled = 1'b0;
                            state_next.cycle_count   = '0;
                            state_next.irq_pending   = 1'b0;
                        end
                        RANGE_A000:
                            state_next.count_enabled = 1'b1;
                        RANGE_C000:
                        begin
                            if (variant_reg)
                                state_next.outer_select = item.bus_address[7:0];
                        end
                        RANGE_E000:
                            state_next.inner_bank = item.bus_data[2:0];
                        default:
                        begin
                        end
                    endcase
                end
                CMD_TICK:
                begin
                    if (state_reg.count_enabled)
                    begin
                        if (state_reg.cycle_count < CNT_W'(IRQ_LIMIT))
                        begin
                            state_next.cycle_count = state_reg.cycle_count
                                + CNT_W'(item.elapsed_cycles);
                        end
                        else
                        begin
                            state_next.count_enabled = 1'b0;
                            state_next.irq_pending   = 1'b1;
                        end
                    end
                end
                CMD_SOFT_RESET:
                    state_next.outer_select = '0;
                default:
                begin
                end
            endcase
        end
    end

    // state and submapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            variant_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                variant_reg <= cfg_wdata;
        end
    end

    assign state_cur = state_reg;

endmodule

>>> rtl/cbm_bank_map.sv
// program and character bank decode from the mapper registers
module cbm_bank_map
    import cbm_pkg::*;
(
    input  cbm_state_t  state,
    output cbm_result_t result
);

    logic [4:0] base32;
    logic [4:0] base16;

    // 32K bank times four, 16K bank times two
    // the bank number is an or with the shifted outer register, so the high
    // outer bits fold onto bits that are already set
    assign base32 = {1'b0, 1'b1, state.outer_select[6], 2'b00};
    assign base16 = {1'b0, 1'b1, state.outer_select[6:5], 1'b0};

    always_comb
    begin
        result.bank_6000         = BANK_FIXED_6000;
        result.chr_bank          = state.outer_select[7:1];
        result.mirror_horizontal = state.outer_select[0];
        result.irq_line          = state.irq_pending;
        if (!state.outer_select[3])
        begin
            result.bank_8000 = BANK_FIXED_8000;
            result.bank_a000 = BANK_FIXED_A000;
            result.bank_c000 = {2'b00, state.inner_bank};
            result.bank_e000 = BANK_FIXED_E000;
        end
        else if (state.outer_select[4])
        begin
            result.bank_8000 = base32;
            result.bank_a000 = base32 | 5'd1;
            result.bank_c000 = base32 | 5'd2;
            result.bank_e000 = base32 | 5'd3;
        end
        else
        begin
            result.bank_8000 = base16;
            result.bank_a000 = base16 | 5'd1;
            result.bank_c000 = base16;
            result.bank_e000 = base16 | 5'd1;
        end
    end

endmodule

>>> rtl/cartridge_bank_mapper_irq.sv
// top level: input register, mapper update, result register
// throughput: one item per cycle while the receiver takes results, a waiting result can stall it
// an input transfer is taken while a result waits if the input register is empty, which then holds it
// reset: rst_n asynchronous active low, clears valid flags, mapper registers, counter and interrupt
module cartridge_bank_mapper_irq
    import cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,       // variant_select
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] bus_address, [23:16] bus_data, [31:24] elapsed_cycles
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,    // [1:0] command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] bank_6000, [9:5] bank_8000, [14:10] bank_a000, [19:15] bank_c000,
    // [24:20] bank_e000, [31:25] chr_bank, [32] mirror_horizontal,
    // [33] irq_line, [39:34] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    cbm_item_t             in_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  advance;
    logic                  s_fire;
    logic                  retire;
    cbm_state_t            state_cur;
    cbm_state_t            state_next;
    cbm_result_t           result;

    // pipeline control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign retire        = in_valid_reg && advance;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.command        <= s_axis_tuser;
            in_item_reg.bus_address    <= s_axis_tdata[15:0];
            in_item_reg.bus_data       <= s_axis_tdata[23:16];
            in_item_reg.elapsed_cycles <= s_axis_tdata[31:24];
        end
    end

    cbm_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fire       (retire),
        .item       (in_item_reg),
        .state_cur  (state_cur),
        .state_next (state_next)
    );

    cbm_bank_map u_bank_map (
        .state  (state_next),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_data_reg <= {6'd0, result.irq_line, result.mirror_horizontal,
                             result.chr_bank, result.bank_e000, result.bank_c000,
                             result.bank_a000, result.bank_8000, result.bank_6000};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // interrupt rises only from a retired tick
    a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_cur.irq_pending) |->
            $past(retire) && $past(in_item_reg.command) == CMD_TICK)
        else $error("interrupt raised without a tick");

    // counter never runs past one tick beyond the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_cur.cycle_count < CNT_W'(IRQ_LIMIT + 256))
        else $error("cycle counter out of range");

    // mapper state only changes when an item retires
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(retire) |-> $stable(state_cur))
        else $error("mapper state changed without an item");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

>>> sim/testbench.sv
// stream-level testbench for the cartridge bank mapper with cycle-counting interrupt
module testbench;
    import cbm_pkg::*;

    // command code that the block must pass through without any state change
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 370;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] bus_address, [23:16] bus_data, [31:24] elapsed_cycles
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;    // [1:0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [4:0] bank_6000, [9:5] bank_8000, [14:10] bank_a000, [19:15] bank_c000,
    // [24:20] bank_e000, [31:25] chr_bank, [32] mirror_horizontal, [33] irq_line
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // mapper state as the predictor sees it
    logic [2:0] pred_inner_bank = '0;
    logic [7:0] pred_outer      = '0;
    int         pred_count      = 0;
    logic       pred_running    = 1'b0;
    logic       pred_irq        = 1'b0;
    logic       pred_variant    = 1'b0;

    cbm_result_t expected_mappings[$];
    int  mismatch_count   = 0;
    int  items_sent       = 0;
    int  stall_cycles     = 0;
    int  sink_hold_cycles = 0;
    bit  sender_idle_en   = 1'b1;
    bit  sink_idle_en     = 1'b1;

    cartridge_bank_mapper_irq uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // advance the mapper state by one command and return the banking it shows
    function automatic cbm_result_t predict_mapping(input logic [1:0] cmd,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] data,
                                                    input logic [7:0] cyc);
        cbm_result_t r;
        int base;
        case (cmd)
            CMD_WRITE:
                case (addr[15:13])
                    RANGE_8000:
                    begin
                        pred_running = 1'b0;
                        pred_count   = 0;
                        pred_irq     = 1'b0;
                    end
                    RANGE_A000: pred_running = 1'b1;
                    RANGE_C000: if (pred_variant) pred_outer = addr[7:0];
                    RANGE_E000: pred_inner_bank = data[2:0];
                    default: ;
                endcase
            CMD_TICK:
                if (pred_running)
                begin
                    // a tick that finds the limit reached stops instead of adding
                    if (pred_count < IRQ_LIMIT)
                        pred_count += cyc;
                    else
                    begin
                        pred_running = 1'b0;
                        pred_irq     = 1'b1;
                    end
                end
            CMD_SOFT_RESET: pred_outer = '0;
            default: ;
        endcase

        r.bank_6000 = BANK_FIXED_6000;
        if (pred_outer[3] && pred_outer[4])
        begin
            // 32K program banking
            base = 4 * (2 | (pred_outer >> 6));
            r.bank_8000 = 5'(base);
            r.bank_a000 = 5'(base + 1);
            r.bank_c000 = 5'(base + 2);
            r.bank_e000 = 5'(base + 3);
        end
        else if (pred_outer[3])
        begin
            // 16K program banking, mirrored into both halves
            base = 2 * (4 | (pred_outer >> 5));
            r.bank_8000 = 5'(base);
            r.bank_a000 = 5'(base + 1);
            r.bank_c000 = 5'(base);
            r.bank_e000 = 5'(base + 1);
        end
        else
        begin
            r.bank_8000 = BANK_FIXED_8000;
            r.bank_a000 = BANK_FIXED_A000;
            r.bank_c000 = {2'b00, pred_inner_bank};
            r.bank_e000 = BANK_FIXED_E000;
        end
        r.chr_bank          = pred_outer[7:1];
        r.mirror_horizontal = pred_outer[0];
        r.irq_line          = pred_irq;
        return r;
    endfunction

    function automatic cbm_result_t unpack_mapping(input logic [OUT_DATA_W-1:0] w);
        cbm_result_t r;
        r.bank_6000         = w[4:0];
        r.bank_8000         = w[9:5];
        r.bank_a000         = w[14:10];
        r.bank_c000         = w[19:15];
        r.bank_e000         = w[24:20];
        r.chr_bank          = w[31:25];
        r.mirror_horizontal = w[32];
        r.irq_line          = w[33];
        return r;
    endfunction

    function automatic string describe_mapping(input cbm_result_t r);
        return $sformatf("banks %0d %0d %0d %0d %0d chr %0d mirror %0d irq %0d",
                         r.bank_6000, r.bank_8000, r.bank_a000, r.bank_c000,
                         r.bank_e000, r.chr_bank, r.mirror_horizontal, r.irq_line);
    endfunction

    // offer one command, wait for its transfer, then record what it should produce
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] data, input logic [7:0] cyc);
        @(negedge clk);
        while (sender_idle_en && $urandom_range(99) < 23)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tuser  = cmd;
        s_axis_tdata  = {cyc, data, addr};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_mappings.push_back(predict_mapping(cmd, addr, data, cyc));
        items_sent++;
    endtask

    // stop offering and wait until every result is back
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_mappings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_variant(input logic value);
        wait_for_results();
        @(negedge clk);
        cfg_we       = 1'b1;
        cfg_wdata    = value;
        pred_variant = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // one command of any kind, with random content in every field
    task automatic send_random_item();
        int pick;
        logic [15:0] addr;
        pick = $urandom_range(99);
        addr = 16'($urandom);
        if (pick < 40)
            send_item(CMD_TICK, addr, 8'($urandom), 8'($urandom));
        else if (pick < 55)
            send_item(CMD_WRITE, {RANGE_E000, addr[12:0]}, 8'($urandom), 8'($urandom));
        else if (pick < 67)
            send_item(CMD_WRITE, {RANGE_C000, addr[12:0]}, 8'($urandom), 8'($urandom));
        else if (pick < 71)
            send_item(CMD_WRITE, {RANGE_A000, addr[12:0]}, 8'($urandom), 8'($urandom));
        else if (pick < 74)
            send_item(CMD_WRITE, {RANGE_8000, addr[12:0]}, 8'($urandom), 8'($urandom));
        else if (pick < 80)
            send_item(CMD_SOFT_RESET, addr, 8'($urandom), 8'($urandom));
        else if (pick < 85)
            send_item(CMD_UNUSED, addr, 8'($urandom), 8'($urandom));
        else if (pick < 92)
            send_item(CMD_WRITE, {1'b0, addr[14:0]}, 8'($urandom), 8'($urandom));
        else
            send_item(2'($urandom), addr, 8'($urandom), 8'($urandom));
    endtask

    // clear, start, then mostly ticks so the counter tends to reach the limit
    task automatic run_counter_sequence();
        int ticks;
        logic [15:0] addr;
        logic [7:0] cyc;
        ticks = $urandom_range(8, 45);
        addr  = 16'($urandom);
        send_item(CMD_WRITE, {RANGE_8000, addr[12:0]}, 8'($urandom), 8'($urandom));
        // now and then the start is left out
        if ($urandom_range(9) != 0)
            send_item(CMD_WRITE, {RANGE_A000, addr[12:0]}, 8'($urandom), 8'($urandom));
        repeat (ticks)
        begin
            if ($urandom_range(99) < 80)
            begin
                cyc = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(128, 255));
                send_item(CMD_TICK, 16'($urandom), 8'($urandom), cyc);
            end
            else
                send_random_item();
        end
    endtask

    // fixed banking, ignored writes, unknown command, soft reset with outer writes off
    task automatic test_fixed_banks();
        send_item(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_WRITE, 16'h7FFF, 8'hFF, 8'hFF);
        send_item(CMD_WRITE, 16'h0000, 8'h00, 8'h00);
        send_item(CMD_WRITE, 16'hE000, 8'hFF, 8'h00);
        send_item(CMD_WRITE, 16'hFFFF, 8'hFA, 8'h00);
        send_item(CMD_WRITE, 16'hC0FF, 8'h00, 8'h00);
        send_item(CMD_SOFT_RESET, 16'h0000, 8'h00, 8'h00);
    endtask

    // outer register modes: 32K, 16K and fixed banking, character bank, mirroring
    task automatic test_outer_register();
        write_variant(1'b1);
        send_item(CMD_WRITE, 16'hC001, 8'h00, 8'h00);
        send_item(CMD_WRITE, 16'hC008, 8'hFF, 8'h00);
        send_item(CMD_WRITE, 16'hC0E8, 8'h00, 8'h00);
        send_item(CMD_WRITE, 16'hC018, 8'h00, 8'h00);
        send_item(CMD_WRITE, 16'hC0D8, 8'h00, 8'h00);
        send_item(CMD_WRITE, 16'hDFFF, 8'h00, 8'h00);
        send_item(CMD_WRITE, 16'hE000, 8'h07, 8'h00);
        send_item(CMD_SOFT_RESET, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_WRITE, 16'hC000, 8'h00, 8'h00);
        write_variant(1'b0);
        send_item(CMD_WRITE, 16'hC0FF, 8'h00, 8'h00);
    endtask

    // counter up to the limit, interrupt raise, restart at the limit and release
    task automatic test_irq_counter();
        send_item(CMD_WRITE, 16'h8000, 8'h00, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        send_item(CMD_WRITE, 16'hA000, 8'h00, 8'h00);
        repeat (16) send_item(CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        send_item(CMD_TICK, 16'h0000, 8'h00, 8'h10);
        send_item(CMD_TICK, 16'h0000, 8'h00, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00, 8'hFF);
        // restart with the count still at the limit
        send_item(CMD_WRITE, 16'hBFFF, 8'h00, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00, 8'h01);
        send_item(CMD_WRITE, 16'h9FFF, 8'hFF, 8'h00);
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        sender_idle_en   = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (40) send_random_item();
        sender_idle_en = 1'b1;
        wait_for_results();
    endtask

    // random traffic over several settings, one phase without any idling
    task automatic test_random_traffic();
        int start;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_variant(phase % 2 == 0);
            sender_idle_en = (phase != 2);
            sink_idle_en   = (phase != 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 60)
                    run_counter_sequence();
                else
                    repeat ($urandom_range(1, 10)) send_random_item();
                // sender pause until the block has drained
                if (phase == 1 && items_sent - start >= PHASE_ITEMS / 2
                    && items_sent - start < PHASE_ITEMS / 2 + 10)
                    wait_for_results();
            end
        end
        sender_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    // receiver ready, with random idling and requested hold-offs
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                sink_hold_cycles--;
            end
            else
                m_axis_tready = rst_n && !(sink_idle_en && $urandom_range(99) < 23);
        end
    end

    // compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        cbm_result_t got;
        cbm_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_mapping(m_axis_tdata);
            if (expected_mappings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %s", describe_mapping(got));
            end
            else
            begin
                want = expected_mappings.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %s, got %s",
                                 describe_mapping(want), describe_mapping(got));
                end
            end
        end
    end

    // watchdog on cycles without any transfer while work is outstanding
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else if (s_axis_tvalid || expected_mappings.size() != 0)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // reset, then the tests in turn
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fixed_banks();
        test_outer_register();
        test_irq_counter();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
